// ===== hw/rtl/mlf_pkg.sv =====
`default_nettype none

package mlf_pkg;

	localparam int QUEUE_SLOTS = 16;
	localparam int LINE_BYTES  = 20;

	localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
	localparam int CNT_W       = $clog2(LINE_BYTES + 1);
	localparam int IDX_W       = $clog2(LINE_BYTES);
	localparam int STORE_DEPTH = QUEUE_SLOTS * LINE_BYTES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int MARK_W      = 4;
	localparam int MARK_MAX    = 15;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [MARK_W-1:0] mark_t;

	localparam logic [7:0] HOLD_CODE = 8'h51;

	// operation codes
	localparam logic [1:0] OP_PUSH    = 2'd0;
	localparam logic [1:0] OP_DRAIN   = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	// result status codes
	localparam logic [2:0] ST_BYTE   = 3'd0;
	localparam logic [2:0] ST_EMPTY  = 3'd1;
	localparam logic [2:0] ST_HOLD   = 3'd2;
	localparam logic [2:0] ST_COMMIT = 3'd3;
	localparam logic [2:0] ST_DROP   = 3'd4;

	// high mark once the ring has been full
	localparam mark_t MARK_AT_FULL =
		mark_t'((QUEUE_SLOTS - 1 > MARK_MAX) ? MARK_MAX : QUEUE_SLOTS - 1);

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] out_byte;
		logic       end_of_entry;
		logic       queue_full;
		mark_t      depth_high_mark;
	} rsp_t;

	function automatic slot_t slot_inc(input slot_t s);
		return (s == slot_t'(QUEUE_SLOTS - 1)) ? '0 : s + slot_t'(1);
	endfunction

	function automatic slot_t depth_of(input slot_t w, input slot_t r);
		logic [SLOT_W:0] d;
		if (w >= r)
			d = {1'b0, w} - {1'b0, r};
		else
			d = {1'b0, w} + (SLOT_W + 1)'(QUEUE_SLOTS) - {1'b0, r};
		return d[SLOT_W-1:0];
	endfunction

	function automatic mark_t mark_cap(input slot_t d);
		if (int'(d) > MARK_MAX)
			return mark_t'(MARK_MAX);
		return mark_t'(d);
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mlf_chan_if.sv =====
`default_nettype none

interface mlf_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, operation, data_byte, last_byte, input ready);
	modport sink   (input valid, operation, data_byte, last_byte, output ready);
endinterface

interface mlf_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] out_byte;
	logic       end_of_entry;
	logic       queue_full;
	logic [3:0] depth_high_mark;

	modport source (output valid, status, out_byte, end_of_entry, queue_full,
		depth_high_mark, input ready);
	modport sink   (input valid, status, out_byte, end_of_entry, queue_full,
		depth_high_mark, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/message_line_fifo_with_hold.sv =====
// message line queue with hold, in front of a serial display link
// cmd channel: one item per push byte, drain request or release; an item is
//   taken when valid and ready are both high
// rsp channel: status results and drained bytes, one per item handshake
// pushes stage bytes into the free ring slot; the byte marked last commits the
//   entry (status committed) or discards it when the ring is full (status
//   dropped), and each gives its result in the cycle after it is taken
// a drain on an empty ring or while the hold is set gives one status result;
//   otherwise the oldest entry leaves one byte per cycle while rsp is ready,
//   the last byte flagged with end_of_entry
// a drain holds the block until its last byte leaves the read stage: the entry
//   store has one read port and each byte passes one read and one output stage
// pushes and releases run at one item per cycle while the output is free
// cmd ready is low during a drain and whenever a result waits on rsp, so a
//   stalled receiver stalls the sender too; nothing is lost or reordered
// reset clears slots, staging count, hold and high mark; the entry store
//   and length table are not cleared, as only committed entries are read

`default_nettype none

module message_line_fifo_with_hold (
	input  logic       clk,
	input  logic       arst_n,
	mlf_cmd_if.sink    cmd,
	mlf_rsp_if.source  rsp
);
	import mlf_pkg::*;

	localparam logic STATE_IDLE  = 1'b0;
	localparam logic STATE_DRAIN = 1'b1;

	// control registers
	logic  state_q;
	slot_t rslot_q;
	slot_t wslot_q;
	cnt_t  staged_q;
	logic  hold_q;
	mark_t mark_q;
	addr_t addr_q;
	idx_t  idx_q;

	// read stage
	logic       vld_s1;
	logic       last_s1;
	logic       chk_s1;
	logic [7:0] rd_data_s1;
	cnt_t       len_rd_q;

	// output register
	logic out_vld_q;
	rsp_t out_q;

	// storage
	logic [7:0] store_mem [STORE_DEPTH];
	cnt_t       len_mem   [QUEUE_SLOTS];

	logic  cmd_acc;
	logic  is_push;
	logic  is_drain;
	logic  is_release;
	logic  room;
	cnt_t  staged_after;
	logic  empty_now;
	logic  full_now;
	logic  commit;
	logic  drop;
	logic  drain_go;
	logic  one_vld;
	logic [2:0] one_st;
	slot_t wslot_nxt;
	mark_t mark_nxt;
	mark_t mark_cand;
	logic  full_nxt;
	addr_t wr_addr;
	logic  mem_we;
	logic  s1_move;
	logic  iss;
	logic  iss_last;

	assign cmd.ready = (state_q == STATE_IDLE) && !vld_s1 && (!out_vld_q || rsp.ready);
	assign cmd_acc   = cmd.valid && cmd.ready;

	assign is_push    = cmd.operation == OP_PUSH;
	assign is_drain   = cmd.operation == OP_DRAIN;
	assign is_release = cmd.operation == OP_RELEASE;

	// bytes beyond the line limit are dropped
	assign room         = staged_q < cnt_t'(LINE_BYTES);
	assign staged_after = room ? staged_q + cnt_t'(1) : staged_q;

	assign empty_now = wslot_q == rslot_q;
	assign full_now  = depth_of(wslot_q, rslot_q) == slot_t'(QUEUE_SLOTS - 1);

	assign commit   = cmd_acc && is_push && cmd.last_byte && !full_now;
	assign drop     = cmd_acc && is_push && cmd.last_byte && full_now;
	assign drain_go = cmd_acc && is_drain && !empty_now && !hold_q;

	assign wslot_nxt = commit ? slot_inc(wslot_q) : wslot_q;
	assign mark_cand = mark_cap(depth_of(wslot_nxt, rslot_q));
	assign mark_nxt  = (commit && mark_cand > mark_q) ? mark_cand : mark_q;
	assign full_nxt  = depth_of(wslot_nxt, rslot_q) == slot_t'(QUEUE_SLOTS - 1);

	// single status results; empty ring is checked before the hold
	always_comb begin
		one_vld = 1'b0;
		one_st  = ST_COMMIT;
		if (cmd_acc) begin
			case (cmd.operation)
				OP_PUSH: begin
					one_vld = cmd.last_byte;
					one_st  = full_now ? ST_DROP : ST_COMMIT;
				end
				OP_DRAIN: begin
					one_vld = empty_now || hold_q;
					one_st  = empty_now ? ST_EMPTY : ST_HOLD;
				end
				default: begin
					one_vld = 1'b0;
				end
			endcase
		end
	end

	// staging writes always go to the free slot, which no drain reads
	assign mem_we  = cmd_acc && is_push && room;
	assign wr_addr = addr_t'(wslot_q) * addr_t'(LINE_BYTES) + addr_t'(staged_q);

	// drain byte sequencer: one store read per cycle while the stages move
	assign s1_move  = vld_s1 && (!out_vld_q || rsp.ready);
	assign iss      = (state_q == STATE_DRAIN) && (!vld_s1 || s1_move);
	assign iss_last = (cnt_t'(idx_q) + cnt_t'(1)) == len_rd_q;

	always_ff @(posedge clk) begin
		if (mem_we)
			store_mem[wr_addr] <= cmd.data_byte;
		if (iss)
			rd_data_s1 <= store_mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (commit)
			len_mem[wslot_q] <= staged_after;
		if (drain_go)
			len_rd_q <= len_mem[rslot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= STATE_IDLE;
			rslot_q  <= '0;
			wslot_q  <= '0;
			staged_q <= '0;
			hold_q   <= 1'b0;
			mark_q   <= '0;
			addr_q   <= '0;
			idx_q    <= '0;
			vld_s1   <= 1'b0;
			last_s1  <= 1'b0;
			chk_s1   <= 1'b0;
		end else begin
			wslot_q <= wslot_nxt;
			mark_q  <= mark_nxt;
			if (cmd_acc && is_push)
				staged_q <= cmd.last_byte ? '0 : staged_after;
			if (drain_go) begin
				state_q <= STATE_DRAIN;
				rslot_q <= slot_inc(rslot_q);
				addr_q  <= addr_t'(rslot_q) * addr_t'(LINE_BYTES);
				idx_q   <= '0;
			end
			if (iss) begin
				addr_q  <= addr_q + addr_t'(1);
				idx_q   <= idx_q + idx_t'(1);
				vld_s1  <= 1'b1;
				last_s1 <= iss_last;
				chk_s1  <= idx_q == idx_t'(1);
				if (iss_last)
					state_q <= STATE_IDLE;
			end else if (s1_move) begin
				vld_s1 <= 1'b0;
			end
			// second byte of the entry decides the hold
			if (s1_move && chk_s1 && rd_data_s1 == HOLD_CODE)
				hold_q <= 1'b1;
			else if (cmd_acc && is_release)
				hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_move || one_vld) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// drained bytes see the ring after the drain took effect
	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q.status          <= ST_BYTE;
			out_q.out_byte        <= rd_data_s1;
			out_q.end_of_entry    <= last_s1;
			out_q.queue_full      <= full_now;
			out_q.depth_high_mark <= mark_q;
		end else if (one_vld) begin
			out_q.status          <= one_st;
			out_q.out_byte        <= '0;
			out_q.end_of_entry    <= 1'b1;
			out_q.queue_full      <= full_nxt;
			out_q.depth_high_mark <= mark_nxt;
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.status          = out_q.status;
	assign rsp.out_byte        = out_q.out_byte;
	assign rsp.end_of_entry    = out_q.end_of_entry;
	assign rsp.queue_full      = out_q.queue_full;
	assign rsp.depth_high_mark = out_q.depth_high_mark;

endmodule

`default_nettype wire

// ===== hw/rtl/mlf_checker.sv =====
`default_nettype none

module mlf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] status,
	input logic [7:0] out_byte,
	input logic       end_of_entry,
	input logic       queue_full,
	input logic [3:0] depth_high_mark
);
	import mlf_pkg::*;

	// status results always close their item and carry no byte
	a_status_closes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_BYTE |-> end_of_entry && out_byte == 8'd0)
		else $error("status result without end flag or with a byte");

	// a full ring implies the high mark has reached it
	a_mark_covers_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && queue_full |-> depth_high_mark >= MARK_AT_FULL)
		else $error("queue full reported above the high mark");

	// no new item is taken while a result waits
	a_stall_blocks_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |-> !cmd_ready)
		else $error("command taken while result stalled");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn under stall");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(status) && $stable(out_byte)
			&& $stable(end_of_entry))
		else $error("result changed under stall");

endmodule

bind message_line_fifo_with_hold mlf_checker u_mlf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_ready       (cmd.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.status          (rsp.status),
	.out_byte        (rsp.out_byte),
	.end_of_entry    (rsp.end_of_entry),
	.queue_full      (rsp.queue_full),
	.depth_high_mark (rsp.depth_high_mark)
);

`default_nettype wire

// ===== sim/message_line_fifo_with_hold_tb.sv =====
`timescale 1ns / 1ps

module message_line_fifo_with_hold_tb;
	import mlf_pkg::*;

	// unused operation code, must be ignored by the block
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int DIR_COUNT      = 14;
	localparam int ITEM_TARGET    = 470;
	localparam int RX_LONG_CYCLES = 300;
	// this covers the tail of any drain, even a full one of LINE_BYTES bytes
	localparam int SETTLE_CYCLES  = 40;

	// one row of the directed part; typed rows carry a single status result
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] b;
		logic       l;
		logic       typed;
		logic [2:0] t_status;
		mark_t      t_mark;
	} dir_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	mlf_cmd_if cmd_ch ();
	mlf_rsp_if rsp_ch ();

	message_line_fifo_with_hold dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// shadow of the ring: slots, staging, hold and high mark
	logic [7:0] line_mem [QUEUE_SLOTS][LINE_BYTES];
	int         line_len [QUEUE_SLOTS];
	int         q_rd     = 0;
	int         q_wr     = 0;
	int         q_staged = 0;
	int         q_mark   = 0;
	bit         q_hold   = 1'b0;

	// results still owed by the block, oldest first
	rsp_t       owed_rsp [$];

	// set by the sender for the item on offer
	bit         typed_now = 1'b0;
	rsp_t       typed_rsp = '0;

	// shared between processes
	bit         idle_on     = 1'b1;
	bit         rx_long_req = 1'b0;
	int         n_sent      = 0;
	int         fail_count  = 0;

	// run statistics, from accepted items and results
	int         n_items  = 0;
	int         n_bytes  = 0;
	int         n_commit = 0;
	int         n_drop   = 0;
	int         n_hold   = 0;
	int         n_empty  = 0;
	int         max_mark = 0;

	dir_row_t   dir_rows [DIR_COUNT];

	function automatic int ring_depth();
		return (q_wr + QUEUE_SLOTS - q_rd) % QUEUE_SLOTS;
	endfunction

	// full flag and high mark are taken after the item has been applied
	function automatic rsp_t line_result(input logic [2:0] st, input logic [7:0] b,
		input logic e);
		rsp_t r;
		r.status          = st;
		r.out_byte        = b;
		r.end_of_entry    = e;
		r.queue_full      = (ring_depth() == QUEUE_SLOTS - 1);
		r.depth_high_mark = mark_t'(q_mark);
		return r;
	endfunction

	// apply one accepted item to the shadow ring and queue what it owes
	task automatic line_queue_apply(input logic [1:0] op, input logic [7:0] b,
		input logic l);
		int d;
		int len;
		int slot;
		case (op)
			OP_PUSH: begin
				// bytes past the line limit are dropped, last still ends the message
				if (q_staged < LINE_BYTES) begin
					line_mem[q_wr][q_staged] = b;
					q_staged++;
				end
				if (l) begin
					if (ring_depth() == QUEUE_SLOTS - 1) begin
						q_staged = 0;
						owed_rsp.push_back(line_result(ST_DROP, 8'h00, 1'b1));
					end else begin
						line_len[q_wr] = q_staged;
						q_wr           = (q_wr + 1) % QUEUE_SLOTS;
						q_staged       = 0;
						d = ring_depth();
						if (d > MARK_MAX)
							d = MARK_MAX;
						if (d > q_mark)
							q_mark = d;
						owed_rsp.push_back(line_result(ST_COMMIT, 8'h00, 1'b1));
					end
				end
			end
			OP_DRAIN: begin
				// empty is checked ahead of the hold
				if (ring_depth() == 0) begin
					owed_rsp.push_back(line_result(ST_EMPTY, 8'h00, 1'b1));
				end else if (q_hold) begin
					owed_rsp.push_back(line_result(ST_HOLD, 8'h00, 1'b1));
				end else begin
					slot = q_rd;
					len  = line_len[slot];
					// a one-byte entry never arms the hold
					if (len >= 2 && line_mem[slot][1] == HOLD_CODE)
						q_hold = 1'b1;
					q_rd = (q_rd + 1) % QUEUE_SLOTS;
					for (int i = 0; i < len; i++)
						owed_rsp.push_back(line_result(ST_BYTE, line_mem[slot][i],
							i == len - 1));
				end
			end
			OP_RELEASE: q_hold = 1'b0;
			default: ;
		endcase
	endtask

	function automatic void check_field(input string name, input logic [7:0] exp_v,
		input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	// sampling at the rising edge: results first, then the accepted item
	always @(posedge clk) begin : monitor
		rsp_t e;
		int   owed_prev;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				case (rsp_ch.status)
					ST_BYTE:   n_bytes++;
					ST_COMMIT: n_commit++;
					ST_DROP:   n_drop++;
					ST_HOLD:   n_hold++;
					ST_EMPTY:  n_empty++;
					default: ;
				endcase
				if (int'(rsp_ch.depth_high_mark) > max_mark)
					max_mark = int'(rsp_ch.depth_high_mark);
				if (owed_rsp.size() == 0) begin
					$display("%0t: unexpected result, status %0h byte %0h", $time,
						rsp_ch.status, rsp_ch.out_byte);
					fail_count++;
				end else begin
					e = owed_rsp.pop_front();
					check_field("status", 8'(e.status), 8'(rsp_ch.status));
					check_field("out_byte", e.out_byte, rsp_ch.out_byte);
					check_field("end_of_entry", 8'(e.end_of_entry), 8'(rsp_ch.end_of_entry));
					check_field("queue_full", 8'(e.queue_full), 8'(rsp_ch.queue_full));
					check_field("depth_high_mark", 8'(e.depth_high_mark),
						8'(rsp_ch.depth_high_mark));
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				n_items++;
				owed_prev = owed_rsp.size();
				line_queue_apply(cmd_ch.operation, cmd_ch.data_byte, cmd_ch.last_byte);
				// a typed row replaces the predicted status with the one written down
				if (typed_now) begin
					while (owed_rsp.size() > owed_prev)
						void'(owed_rsp.pop_back());
					owed_rsp.push_back(typed_rsp);
				end
			end
		end
	end

	// receiver: random stall per result, plus one long hold-off on request
	initial begin : receiver
		int w;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_long_req) begin
				rsp_ch.ready <= 1'b0;
				rx_long_req = 1'b0;
				repeat (RX_LONG_CYCLES) @(negedge clk);
			end
			w = idle_on ? $urandom_range(0, 7) : 0;
			if (w > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	// offer one item after a random gap; returns at the falling edge after acceptance
	task automatic send_item(input logic [1:0] op, input logic [7:0] b, input logic l,
		input bit typed, input rsp_t trsp);
		int gap;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.data_byte <= b;
		cmd_ch.last_byte <= l;
		typed_now = typed;
		typed_rsp = trsp;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		@(negedge clk);
		if (op != OP_UNUSED)
			n_sent++;
	endtask

	task automatic send_plain(input logic [1:0] op);
		send_item(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
	endtask

	// a whole message; the hold tag puts the hold code in the second byte
	task automatic send_message(input int len, input bit hold_tag);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = (i == 1 && hold_tag) ? HOLD_CODE : 8'($urandom_range(0, 255));
			send_item(OP_PUSH, b, i == len - 1, 1'b0, '0);
		end
	endtask

	initial begin : stimulus
		int       pick;
		int       len;
		bit       long_done;
		bit       pause_done;
		dir_row_t row;
		rsp_t     trsp;

		long_done  = 1'b0;
		pause_done = 1'b0;

		// typed rows: status results read straight off the ring state
		dir_rows = '{
			'{OP_DRAIN,   8'h00, 1'b0, 1'b1, ST_EMPTY,  4'd0},  // drain on empty after reset
			'{OP_RELEASE, 8'h00, 1'b0, 1'b0, ST_BYTE,   4'd0},  // release with no hold
			'{OP_UNUSED,  8'hff, 1'b1, 1'b0, ST_BYTE,   4'd0},  // unused code, ignored
			'{OP_PUSH,    8'h00, 1'b0, 1'b0, ST_BYTE,   4'd0},
			'{OP_PUSH,    HOLD_CODE, 1'b0, 1'b0, ST_BYTE, 4'd0}, // second byte arms hold
			'{OP_PUSH,    8'hff, 1'b1, 1'b1, ST_COMMIT, 4'd1},
			'{OP_PUSH,    HOLD_CODE, 1'b1, 1'b1, ST_COMMIT, 4'd2}, // one-byte entry
			'{OP_PUSH,    8'h80, 1'b1, 1'b1, ST_COMMIT, 4'd3},
			'{OP_DRAIN,   8'hff, 1'b0, 1'b0, ST_BYTE,   4'd0},  // three bytes, sets hold
			'{OP_DRAIN,   8'h00, 1'b1, 1'b1, ST_HOLD,   4'd3},  // refused while held
			'{OP_RELEASE, 8'hff, 1'b1, 1'b0, ST_BYTE,   4'd0},
			'{OP_DRAIN,   8'h00, 1'b0, 1'b0, ST_BYTE,   4'd0},  // short entry, no hold
			'{OP_DRAIN,   8'hff, 1'b1, 1'b0, ST_BYTE,   4'd0},
			'{OP_DRAIN,   8'h00, 1'b0, 1'b1, ST_EMPTY,  4'd3}
		};

		cmd_ch.valid     <= 1'b0;
		cmd_ch.operation <= OP_PUSH;
		cmd_ch.data_byte <= 8'h00;
		cmd_ch.last_byte <= 1'b0;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part
		for (int i = 0; i < DIR_COUNT; i++) begin
			row  = dir_rows[i];
			trsp = '{status: row.t_status, out_byte: 8'h00, end_of_entry: 1'b1,
				queue_full: 1'b0, depth_high_mark: row.t_mark};
			send_item(row.op, row.b, row.l, row.typed, trsp);
		end

		// random part: mostly whole messages and drains, some bursts and noise
		while (n_sent < ITEM_TARGET) begin
			// every fourth stretch runs with no idling on either side
			idle_on = ((n_sent / 50) % 4) != 3;

			// receiver stops for a long while, sender keeps offering
			if (!long_done && n_sent >= 150) begin
				rx_long_req = 1'b1;
				long_done   = 1'b1;
			end
			// sender waits until the block has paid out everything
			if (!pause_done && n_sent >= 320) begin
				cmd_ch.valid <= 1'b0;
				@(negedge clk);
				while (owed_rsp.size() != 0)
					@(negedge clk);
				pause_done = 1'b1;
			end

			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 24)
					: $urandom_range(1, 20);
				send_message(len, $urandom_range(0, 3) == 0);
			end else if (pick < 68) begin
				send_plain(OP_DRAIN);
			end else if (pick < 78) begin
				send_plain(OP_RELEASE);
			end else if (pick < 84) begin
				send_plain(OP_UNUSED);
			end else if (pick < 92) begin
				// fill the ring to the brim so later commits are dropped
				repeat ($urandom_range(14, 18))
					send_message($urandom_range(1, 3), 1'b0);
			end else begin
				// run of drains with releases mixed in
				repeat ($urandom_range(2, 6)) begin
					if ($urandom_range(0, 2) == 0)
						send_plain(OP_RELEASE);
					send_plain(OP_DRAIN);
				end
			end
		end

		cmd_ch.valid <= 1'b0;
		while (owed_rsp.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("run: %0d items taken, %0d drained bytes, %0d commits, %0d drops",
			n_items, n_bytes, n_commit, n_drop);
		$display("run: %0d hold refusals, %0d empty drains, high mark reached %0d",
			n_hold, n_empty, max_mark);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// overall time limit, well beyond the slowest correct run
	initial begin : watchdog
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== message_line_fifo_with_hold.f =====
hw/rtl/mlf_pkg.sv
hw/rtl/mlf_chan_if.sv
hw/rtl/message_line_fifo_with_hold.sv
hw/rtl/mlf_checker.sv
sim/message_line_fifo_with_hold_tb.sv
